// ===== design/assert_macros.svh =====
// ============================================================================
// Assertion macros
// Shared wrappers for the concurrent assertions of the summed-area block.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen at a rising edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== design/sat_pkg.sv =====
// ============================================================================
// Summed-area table package
// Widths, register indexes and status codes shared by the block's modules.
// ============================================================================
package sat_pkg;

    localparam int DEF_MAX_ROWS = 256;
    localparam int DEF_MAX_COLS = 256;

    localparam int CFG_W    = 9;   // width of a count register
    localparam int CNT_W    = 13;  // holds any count up to the largest table
    localparam int IDX_W    = 2;   // register index on the write port
    localparam int ELEM_W   = 16;
    localparam int SUM_W    = 32;
    localparam int COORD_W  = 8;
    localparam int STATUS_W = 2;

    localparam logic [IDX_W-1:0] REG_ROW_COUNT = 2'd0;
    localparam logic [IDX_W-1:0] REG_COL_COUNT = 2'd1;

    localparam logic [CFG_W-1:0] COUNT_RESET = 9'd256;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_BAD_RECT   = 2'd1,
        ST_NOT_LOADED = 2'd2
    } t_status;

    // Write and read enables of the table memory.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

endpackage

// ===== design/summed_area_rect_sum.sv =====
// ============================================================================
// Summed-area rectangle sum
// Builds a 2-D prefix-sum table in memory and answers rectangle-sum queries.
// ============================================================================
// Usage. Requests arrive on the input channel (i_in_valid / o_in_ready). A
// load request (i_op = 0) takes the next matrix element in row-major order
// over the configured row_count x column_count matrix and gives no result.
// A query request (i_op = 1) gives one result on the output channel
// (o_out_valid / i_out_ready): the rectangle sum and a status code.
// Sequencing: the block works on one request at a time. A load reads the
// entry above through one table read port, then writes the new entry back.
// A valid query reads its corners in two steps, two read ports each, then
// forms the final sum and moves it to the output register; a flagged query
// goes straight to the output register. Loads never overlap because each
// write lands before the next read is issued.
// Reset clears the load position, row sum and full mark and sets both counts
// to 256 (clipped to the table size). Table contents are not cleared: every
// entry a query uses has been written by the current load pass. A count
// register write restarts loading. Queries before the table is full report
// "not loaded". A stalled receiver holds the result in the output register;
// the block finishes the next request's work, then waits for that register.
// ============================================================================
module summed_area_rect_sum #(
    parameter int MAX_ROWS = sat_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = sat_pkg::DEF_MAX_COLS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [sat_pkg::IDX_W-1:0]         i_cfg_index,
    input  logic [sat_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_op,
    input  logic signed [sat_pkg::ELEM_W-1:0] i_element_value,
    input  logic [sat_pkg::COORD_W-1:0]       i_top_row,
    input  logic [sat_pkg::COORD_W-1:0]       i_left_col,
    input  logic [sat_pkg::COORD_W-1:0]       i_bottom_row,
    input  logic [sat_pkg::COORD_W-1:0]       i_right_col,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [sat_pkg::SUM_W-1:0]  o_rect_sum,
    output logic [sat_pkg::STATUS_W-1:0]      o_status
);
    import sat_pkg::*;

    // Table address is {row, column}; each part is as wide as its maximum needs.
    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ADDR_W = ROW_W + COL_W;

    t_mem_ctl          mem_ctl;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr_a;
    logic [ADDR_W-1:0] rd_addr_b;
    logic [SUM_W-1:0]  wr_data;
    logic [SUM_W-1:0]  rd_data_a;
    logic [SUM_W-1:0]  rd_data_b;

    sat_mem #(
        .ADDR_W (ADDR_W)
    ) u_mem (
        .i_clk       (i_clk),
        .i_ctl       (mem_ctl),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .i_rd_addr_a (rd_addr_a),
        .i_rd_addr_b (rd_addr_b),
        .o_rd_data_a (rd_data_a),
        .o_rd_data_b (rd_data_b)
    );

    sat_ctrl #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS),
        .ROW_W    (ROW_W),
        .COL_W    (COL_W)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_op            (i_op),
        .i_element_value (i_element_value),
        .i_top_row       (i_top_row),
        .i_left_col      (i_left_col),
        .i_bottom_row    (i_bottom_row),
        .i_right_col     (i_right_col),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_rect_sum      (o_rect_sum),
        .o_status        (o_status),
        .o_mem_ctl       (mem_ctl),
        .o_wr_addr       (wr_addr),
        .o_wr_data       (wr_data),
        .o_rd_addr_a     (rd_addr_a),
        .o_rd_addr_b     (rd_addr_b),
        .i_rd_data_a     (rd_data_a),
        .i_rd_data_b     (rd_data_b)
    );

endmodule

// ===== design/sat_mem.sv =====
// ============================================================================
// Summed-area table memory
// One write port and two read ports, read data registered.
// ============================================================================
module sat_mem #(
    parameter int ADDR_W = 16
) (
    input  logic                       i_clk,
    input  sat_pkg::t_mem_ctl          i_ctl,
    input  logic [ADDR_W-1:0]          i_wr_addr,
    input  logic [sat_pkg::SUM_W-1:0]  i_wr_data,
    input  logic [ADDR_W-1:0]          i_rd_addr_a,
    input  logic [ADDR_W-1:0]          i_rd_addr_b,
    output logic [sat_pkg::SUM_W-1:0]  o_rd_data_a,
    output logic [sat_pkg::SUM_W-1:0]  o_rd_data_b
);
    import sat_pkg::*;

    localparam int DEPTH = 1 << ADDR_W;

    logic [SUM_W-1:0] r_mem [0:DEPTH-1];
    logic [SUM_W-1:0] r_rd_a;
    logic [SUM_W-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_a <= r_mem[i_rd_addr_a];
            r_rd_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

// ===== design/sat_ctrl.sv =====
// ============================================================================
// Summed-area table controller
// Load sequencing, query corner reads, result arithmetic and output register.
// ============================================================================
`include "assert_macros.svh"

module sat_ctrl #(
    parameter int MAX_ROWS = sat_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = sat_pkg::DEF_MAX_COLS,
    parameter int ROW_W    = 8,
    parameter int COL_W    = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [sat_pkg::IDX_W-1:0]     i_cfg_index,
    input  logic [sat_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_op,
    input  logic signed [sat_pkg::ELEM_W-1:0] i_element_value,
    input  logic [sat_pkg::COORD_W-1:0]   i_top_row,
    input  logic [sat_pkg::COORD_W-1:0]   i_left_col,
    input  logic [sat_pkg::COORD_W-1:0]   i_bottom_row,
    input  logic [sat_pkg::COORD_W-1:0]   i_right_col,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [sat_pkg::SUM_W-1:0] o_rect_sum,
    output logic [sat_pkg::STATUS_W-1:0]  o_status,
    output sat_pkg::t_mem_ctl             o_mem_ctl,
    output logic [ROW_W+COL_W-1:0]        o_wr_addr,
    output logic [sat_pkg::SUM_W-1:0]     o_wr_data,
    output logic [ROW_W+COL_W-1:0]        o_rd_addr_a,
    output logic [ROW_W+COL_W-1:0]        o_rd_addr_b,
    input  logic [sat_pkg::SUM_W-1:0]     i_rd_data_a,
    input  logic [sat_pkg::SUM_W-1:0]     i_rd_data_b
);
    import sat_pkg::*;

    localparam logic [CNT_W-1:0] ROWS_MAX = CNT_W'(MAX_ROWS);
    localparam logic [CNT_W-1:0] COLS_MAX = CNT_W'(MAX_COLS);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_LWR  = 5'b00010,
        S_Q2   = 5'b00100,
        S_Q3   = 5'b01000,
        S_QOUT = 5'b10000
    } t_state;

    // A count of zero acts as one; anything above the table size is clipped.
    function automatic logic [CNT_W-1:0] clamp_count(
        input logic [CFG_W-1:0] v,
        input logic [CNT_W-1:0] mx
    );
        logic [CNT_W-1:0] w;
        w = CNT_W'(v);
        if (w == '0) begin
            return CNT_W'(1);
        end
        return (w > mx) ? mx : w;
    endfunction

    t_state            r_state,     n_state;
    logic [CNT_W-1:0]  r_rows,      n_rows;
    logic [CNT_W-1:0]  r_cols,      n_cols;
    logic [CNT_W-1:0]  r_load_row,  n_load_row;
    logic [CNT_W-1:0]  r_load_col,  n_load_col;
    logic [SUM_W-1:0]  r_run,       n_run;
    logic              r_full,      n_full;
    logic [ROW_W-1:0]  r_q_bot,     n_q_bot;
    logic [ROW_W-1:0]  r_q_above,   n_q_above;
    logic [COL_W-1:0]  r_q_left,    n_q_left;
    logic              r_top_nz,    n_top_nz;
    logic              r_left_nz,   n_left_nz;
    logic [SUM_W-1:0]  r_acc,       n_acc;
    logic [SUM_W-1:0]  r_res_sum,   n_res_sum;
    t_status           r_res_st,    n_res_st;
    logic              r_out_valid, n_out_valid;
    logic [SUM_W-1:0]  r_out_sum,   n_out_sum;
    t_status           r_out_st,    n_out_st;

    logic [CNT_W-1:0]  top_ext, left_ext, bot_ext, right_ext;
    logic [CNT_W-1:0]  col_next, row_next;
    logic [SUM_W-1:0]  elem_ext;
    logic              rect_bad;
    logic              load_skip;

    always_comb begin
        top_ext   = CNT_W'(i_top_row);
        left_ext  = CNT_W'(i_left_col);
        bot_ext   = CNT_W'(i_bottom_row);
        right_ext = CNT_W'(i_right_col);
        elem_ext  = SUM_W'(i_element_value);
        col_next  = r_load_col + CNT_W'(1);
        row_next  = r_load_row + CNT_W'(1);
        rect_bad  = (top_ext > bot_ext) || (left_ext > right_ext) ||
                    (bot_ext >= r_rows) || (right_ext >= r_cols);
        load_skip = r_full || (r_load_row >= r_rows) || (r_load_col >= r_cols);
    end

    always_comb begin
        logic [CNT_W-1:0] above_row;
        logic [CNT_W-1:0] top_m1;
        logic [CNT_W-1:0] left_m1;
        above_row = r_load_row - CNT_W'(1);
        top_m1    = top_ext - CNT_W'(1);
        left_m1   = left_ext - CNT_W'(1);

        n_state     = r_state;
        n_rows      = r_rows;
        n_cols      = r_cols;
        n_load_row  = r_load_row;
        n_load_col  = r_load_col;
        n_run       = r_run;
        n_full      = r_full;
        n_q_bot     = r_q_bot;
        n_q_above   = r_q_above;
        n_q_left    = r_q_left;
        n_top_nz    = r_top_nz;
        n_left_nz   = r_left_nz;
        n_acc       = r_acc;
        n_res_sum   = r_res_sum;
        n_res_st    = r_res_st;
        n_out_valid = r_out_valid;
        n_out_sum   = r_out_sum;
        n_out_st    = r_out_st;

        o_mem_ctl   = '0;
        o_wr_addr   = {r_load_row[ROW_W-1:0], r_load_col[COL_W-1:0]};
        o_wr_data   = r_run + ((r_load_row != '0) ? i_rd_data_a : '0);
        o_rd_addr_a = {above_row[ROW_W-1:0], r_load_col[COL_W-1:0]};
        o_rd_addr_b = {top_m1[ROW_W-1:0], right_ext[COL_W-1:0]};

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (!i_op) begin
                        if (!load_skip) begin
                            // Row sum now; the entry above arrives next cycle.
                            n_run         = r_run + elem_ext;
                            o_mem_ctl.rd_en = 1'b1;
                            n_state       = S_LWR;
                        end
                    end else if (!r_full) begin
                        n_res_sum = '0;
                        n_res_st  = ST_NOT_LOADED;
                        n_state   = S_QOUT;
                    end else if (rect_bad) begin
                        n_res_sum = '0;
                        n_res_st  = ST_BAD_RECT;
                        n_state   = S_QOUT;
                    end else begin
                        o_mem_ctl.rd_en = 1'b1;
                        o_rd_addr_a = {bot_ext[ROW_W-1:0], right_ext[COL_W-1:0]};
                        n_q_bot   = bot_ext[ROW_W-1:0];
                        n_q_above = top_m1[ROW_W-1:0];
                        n_q_left  = left_m1[COL_W-1:0];
                        n_top_nz  = (i_top_row != '0);
                        n_left_nz = (i_left_col != '0);
                        n_state   = S_Q2;
                    end
                end
            end
            S_LWR: begin
                o_mem_ctl.wr_en = 1'b1;
                if (col_next >= r_cols) begin
                    n_load_col = '0;
                    n_run      = '0;
                    n_load_row = row_next;
                    if (row_next >= r_rows) begin
                        n_full = 1'b1;
                    end
                end else begin
                    n_load_col = col_next;
                end
                n_state = S_IDLE;
            end
            S_Q2: begin
                n_acc = i_rd_data_a - (r_top_nz ? i_rd_data_b : '0);
                o_mem_ctl.rd_en = 1'b1;
                o_rd_addr_a = {r_q_bot, r_q_left};
                o_rd_addr_b = {r_q_above, r_q_left};
                n_state = S_Q3;
            end
            S_Q3: begin
                n_res_sum = r_acc - (r_left_nz ? i_rd_data_a : '0)
                          + ((r_top_nz && r_left_nz) ? i_rd_data_b : '0);
                n_res_st  = ST_OK;
                n_state   = S_QOUT;
            end
            S_QOUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_sum   = r_res_sum;
                    n_out_st    = r_res_st;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // A write to the row or column count register restarts the load pass.
        if (i_cfg_we) begin
            if (i_cfg_index == REG_ROW_COUNT || i_cfg_index == REG_COL_COUNT) begin
                if (i_cfg_index == REG_ROW_COUNT) begin
                    n_rows = clamp_count(i_cfg_data, ROWS_MAX);
                end else begin
                    n_cols = clamp_count(i_cfg_data, COLS_MAX);
                end
                n_load_row = '0;
                n_load_col = '0;
                n_run      = '0;
                n_full     = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rows      <= clamp_count(COUNT_RESET, ROWS_MAX);
            r_cols      <= clamp_count(COUNT_RESET, COLS_MAX);
            r_load_row  <= '0;
            r_load_col  <= '0;
            r_run       <= '0;
            r_full      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rows      <= n_rows;
            r_cols      <= n_cols;
            r_load_row  <= n_load_row;
            r_load_col  <= n_load_col;
            r_run       <= n_run;
            r_full      <= n_full;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q_bot   <= n_q_bot;
        r_q_above <= n_q_above;
        r_q_left  <= n_q_left;
        r_top_nz  <= n_top_nz;
        r_left_nz <= n_left_nz;
        r_acc     <= n_acc;
        r_res_sum <= n_res_sum;
        r_res_st  <= n_res_st;
        r_out_sum <= n_out_sum;
        r_out_st  <= n_out_st;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_rect_sum  = r_out_sum;
    assign o_status    = r_out_st;

    `ASSERT_CLK(a_load_pos_in_range, i_clk, i_rst_n,
        !r_full |-> (r_load_col < r_cols && r_load_row < r_rows),
        "load position outside the configured matrix")
    `ASSERT_CLK(a_full_sticky, i_clk, i_rst_n,
        (r_full && !i_cfg_we) |=> r_full,
        "table lost its full mark without a register write")
    `ASSERT_CLK(a_load_no_result, i_clk, i_rst_n,
        (i_in_valid && o_in_ready && !i_op) |=> (r_state == S_LWR || r_state == S_IDLE),
        "a load request entered the query path")

endmodule

// ===== test/summed_area_rect_sum_tb.sv =====
// ============================================================================
// Summed-area rectangle sum testbench
// Loads matrices of many shapes into the block, asks rectangle sums and
// compares every answer with a prefix table kept alongside in the bench.
// ============================================================================
module summed_area_rect_sum_tb;

    import sat_pkg::*;

    localparam int TABLE_ROWS = DEF_MAX_ROWS;
    localparam int TABLE_COLS = DEF_MAX_COLS;

    // Request kinds on the i_op field.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Register indexes that lie past the end of the register list.
    localparam logic [IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [IDX_W-1:0] REG_SPARE_3 = 2'd3;

    // Ways in which the result receiver takes or refuses results.
    localparam int RX_ALWAYS  = 0;
    localparam int RX_RANDOM  = 1;
    localparam int RX_SPARSE  = 2;
    localparam int RX_PATTERN = 3;

    localparam int RX_HOLD_CYCLES   = 200;
    localparam int SETTLE_CYCLES    = 8;
    localparam int RANDOM_REQUESTS  = 1000;
    localparam int MAX_PRINTED      = 30;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        t_status                 status;
    } t_rect_result;

    // ------------------------------------------------------------------------
    // Block ports. Every input holds a known value from time zero.
    // ------------------------------------------------------------------------
    logic                     i_clk           = 1'b0;
    logic                     i_rst_n         = 1'b0;
    logic                     i_cfg_we        = 1'b0;
    logic [IDX_W-1:0]         i_cfg_index     = '0;
    logic [CFG_W-1:0]         i_cfg_data      = '0;
    logic                     i_in_valid      = 1'b0;
    logic                     o_in_ready;
    logic                     i_op            = OP_LOAD;
    logic signed [ELEM_W-1:0] i_element_value = '0;
    logic [COORD_W-1:0]       i_top_row       = '0;
    logic [COORD_W-1:0]       i_left_col      = '0;
    logic [COORD_W-1:0]       i_bottom_row    = '0;
    logic [COORD_W-1:0]       i_right_col     = '0;
    logic                     o_out_valid;
    logic                     i_out_ready     = 1'b0;
    logic signed [SUM_W-1:0]  o_rect_sum;
    logic [STATUS_W-1:0]      o_status;

    summed_area_rect_sum dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_op            (i_op),
        .i_element_value (i_element_value),
        .i_top_row       (i_top_row),
        .i_left_col      (i_left_col),
        .i_bottom_row    (i_bottom_row),
        .i_right_col     (i_right_col),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_rect_sum      (o_rect_sum),
        .o_status        (o_status)
    );

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Bench copy of the block's state: the prefix table, the load position,
    // the running row sum and the full mark, plus the two count registers.
    // ------------------------------------------------------------------------
    logic [SUM_W-1:0] prefix_mem [TABLE_ROWS*TABLE_COLS];
    logic [CFG_W-1:0] row_cfg     = COUNT_RESET;
    logic [CFG_W-1:0] col_cfg     = COUNT_RESET;
    int               load_row    = 0;
    int               load_col    = 0;
    logic [SUM_W-1:0] row_sum     = '0;
    bit               table_full  = 1'b0;

    // Answers owed by the block, oldest first.
    t_rect_result rect_results_due[$];

    int  mismatch_count = 0;
    int  requests_sent  = 0;
    bit  sender_bursty  = 1'b1;
    int  burst_left     = 0;

    // Receiver state. A test raises hold_off_req and the receiver process
    // itself counts out the long stall.
    bit       hold_off_req = 1'b0;
    int       rx_hold_left = 0;
    int       rx_mode      = RX_ALWAYS;
    int       rx_left      = 0;
    bit [7:0] rx_pattern   = 8'b1011_0010;
    t_rect_result due;

    // A count of zero behaves as one and anything past the table size is
    // clipped to it.
    function automatic int clamp_count(input logic [CFG_W-1:0] v, input int max_count);
        if (v == 0) return 1;
        return (v > max_count) ? max_count : int'(v);
    endfunction

    function automatic int rows_in_use();
        return clamp_count(row_cfg, TABLE_ROWS);
    endfunction

    function automatic int cols_in_use();
        return clamp_count(col_cfg, TABLE_COLS);
    endfunction

    // Advances the bench table for one accepted request and, for a query,
    // queues the answer that the block owes.
    function automatic void track_request(input logic op, input logic [ELEM_W-1:0] elem,
                                          input logic [COORD_W-1:0] t, input logic [COORD_W-1:0] l,
                                          input logic [COORD_W-1:0] b, input logic [COORD_W-1:0] r);
        int               rows;
        int               cols;
        int               top;
        int               lft;
        int               bot;
        int               rgt;
        logic [SUM_W-1:0] entry;
        t_rect_result     res;
        rows = rows_in_use();
        cols = cols_in_use();
        top  = int'(t);
        lft  = int'(l);
        bot  = int'(b);
        rgt  = int'(r);
        if (op == OP_LOAD) begin
            // Loads beyond a complete table fall on the floor.
            if (table_full || load_row >= rows || load_col >= cols) return;
            row_sum += {{(SUM_W-ELEM_W){elem[ELEM_W-1]}}, elem};
            entry = row_sum;
            if (load_row > 0) entry += prefix_mem[(load_row-1)*TABLE_COLS + load_col];
            prefix_mem[load_row*TABLE_COLS + load_col] = entry;
            load_col++;
            if (load_col >= cols) begin
                load_col = 0;
                row_sum  = '0;
                load_row++;
                if (load_row >= rows) table_full = 1'b1;
            end
        end else begin
            res.sum = '0;
            // The not-loaded check wins over the rectangle check.
            if (!table_full) begin
                res.status = ST_NOT_LOADED;
            end else if (top > bot || lft > rgt || bot >= rows || rgt >= cols) begin
                res.status = ST_BAD_RECT;
            end else begin
                res.status = ST_OK;
                entry = prefix_mem[bot*TABLE_COLS + rgt];
                if (top > 0) entry -= prefix_mem[(top-1)*TABLE_COLS + rgt];
                if (lft > 0) entry -= prefix_mem[bot*TABLE_COLS + lft - 1];
                if (top > 0 && lft > 0) entry += prefix_mem[(top-1)*TABLE_COLS + lft - 1];
                res.sum = entry;
            end
            rect_results_due.push_back(res);
        end
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_PRINTED) $display("MISMATCH: %s", msg);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------------
    // Request sender. Valid is raised and held with a steady payload until
    // the block takes the request; the bench table is advanced at that edge.
    // In bursty mode the sender drops valid between bursts of random length.
    // ------------------------------------------------------------------------
    task automatic send_request(input logic op, input logic [ELEM_W-1:0] elem,
                                input logic [COORD_W-1:0] t, input logic [COORD_W-1:0] l,
                                input logic [COORD_W-1:0] b, input logic [COORD_W-1:0] r);
        i_in_valid      <= 1'b1;
        i_op            <= op;
        i_element_value <= elem;
        i_top_row       <= t;
        i_left_col      <= l;
        i_bottom_row    <= b;
        i_right_col     <= r;
        do @(posedge i_clk); while (!o_in_ready);
        track_request(op, elem, t, l, b, r);
        requests_sent++;
        if (sender_bursty) begin
            if (burst_left == 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
                burst_left = $urandom_range(1, 12);
            end else begin
                burst_left--;
            end
        end
    endtask

    // The coordinate fields of a load are ignored, so they carry noise.
    task automatic send_load(input logic [ELEM_W-1:0] elem);
        send_request(OP_LOAD, elem, COORD_W'($urandom), COORD_W'($urandom),
                     COORD_W'($urandom), COORD_W'($urandom));
    endtask

    task automatic send_query(input logic [COORD_W-1:0] t, input logic [COORD_W-1:0] l,
                              input logic [COORD_W-1:0] b, input logic [COORD_W-1:0] r);
        send_request(OP_QUERY, ELEM_W'($urandom), t, l, b, r);
    endtask

    // Element values lean towards the extremes so that the sums run large.
    function automatic logic [ELEM_W-1:0] rand_element();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'hFFFF;
            default: return ELEM_W'($urandom);
        endcase
    endfunction

    task automatic load_elements(input int count);
        repeat (count) send_load(rand_element());
    endtask

    // A rectangle that lies inside the matrix as configured now.
    task automatic query_inside();
        int t;
        int l;
        int b;
        int r;
        t = $urandom_range(0, rows_in_use() - 1);
        b = $urandom_range(t, rows_in_use() - 1);
        l = $urandom_range(0, cols_in_use() - 1);
        r = $urandom_range(l, cols_in_use() - 1);
        send_query(COORD_W'(t), COORD_W'(l), COORD_W'(b), COORD_W'(r));
    endtask

    task automatic query_noise();
        send_query(COORD_W'($urandom_range(0, 255)), COORD_W'($urandom_range(0, 255)),
                   COORD_W'($urandom_range(0, 255)), COORD_W'($urandom_range(0, 255)));
    endtask

    // The sender stops and waits for every owed answer, then waits out the
    // settle time so that a trailing load has landed in the table.
    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        while (rect_results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // A write to a listed register restarts loading; spare indexes do
    // nothing at all.
    task automatic write_register(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_ROW_COUNT || idx == REG_COL_COUNT) begin
            if (idx == REG_ROW_COUNT) row_cfg = value;
            else col_cfg = value;
            load_row   = 0;
            load_col   = 0;
            row_sum    = '0;
            table_full = 1'b0;
        end
        @(posedge i_clk);
    endtask

    task automatic set_shape(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols);
        wait_results_drained();
        write_register(REG_ROW_COUNT, rows);
        write_register(REG_COL_COUNT, cols);
    endtask

    // ------------------------------------------------------------------------
    // Result receiver. It switches between its manners at random, and on
    // request it refuses results for a long stretch so that the block backs
    // up and stops taking requests.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_off_req) begin
            hold_off_req = 1'b0;
            rx_hold_left = RX_HOLD_CYCLES;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = $urandom_range(RX_ALWAYS, RX_PATTERN);
                rx_left = $urandom_range(16, 96);
            end else begin
                rx_left--;
            end
            case (rx_mode)
                RX_ALWAYS: i_out_ready <= 1'b1;
                RX_RANDOM: i_out_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: i_out_ready <= ($urandom_range(0, 3) == 0);
                default: begin
                    i_out_ready <= rx_pattern[0];
                    rx_pattern = {rx_pattern[0], rx_pattern[7:1]};
                end
            endcase
        end
    end

    // Every answer taken is held against the oldest one owed.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (rect_results_due.size() == 0) begin
                report_mismatch($sformatf("answer with no query waiting: sum %0d status %0d",
                                          o_rect_sum, o_status));
            end else begin
                due = rect_results_due.pop_front();
                if (o_status !== due.status)
                    report_mismatch($sformatf("status %0d, wanted %0d", o_status, due.status));
                if (o_rect_sum !== due.sum)
                    report_mismatch($sformatf("rect_sum %0d, wanted %0d", o_rect_sum, due.sum));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Straight out of reset the matrix is 256 x 256 and empty, so every
    // query is refused as not loaded, reversed rectangles included.
    task automatic test_reset_shape();
        send_query(8'd0, 8'd0, 8'd0, 8'd0);
        send_query(8'd255, 8'd255, 8'd255, 8'd255);
        send_query(8'd200, 8'd10, 8'd3, 8'd9);
        load_elements(5);
        query_noise();
        send_query(8'd0, 8'd0, 8'd255, 8'd255);
        wait_results_drained();
    endtask

    // A 2 x 3 matrix of extreme values, with queries over every kind of
    // rectangle and the flagged cases.
    task automatic test_small_matrix();
        set_shape(9'd2, 9'd3);
        send_load(16'h7FFF);
        send_load(16'h8000);
        send_load(16'hFFFF);
        send_query(8'd0, 8'd0, 8'd0, 8'd0);
        send_query(8'd1, 8'd0, 8'd0, 8'd0);
        send_load(16'h0000);
        send_load(16'h7FFF);
        send_load(16'h7FFF);
        send_query(8'd0, 8'd0, 8'd1, 8'd2);
        send_query(8'd0, 8'd0, 8'd0, 8'd0);
        send_query(8'd1, 8'd2, 8'd1, 8'd2);
        send_query(8'd1, 8'd1, 8'd1, 8'd2);
        send_query(8'd0, 8'd1, 8'd1, 8'd1);
        send_query(8'd1, 8'd0, 8'd0, 8'd0);
        send_query(8'd0, 8'd2, 8'd1, 8'd1);
        send_query(8'd0, 8'd0, 8'd2, 8'd0);
        send_query(8'd0, 8'd0, 8'd1, 8'd3);
        send_query(8'd255, 8'd255, 8'd255, 8'd255);
        // The table is complete, so this load must change nothing.
        send_load(16'h1234);
        send_query(8'd0, 8'd0, 8'd1, 8'd2);
        wait_results_drained();
    endtask

    // Counts at and beyond their limits, spare register indexes, and a
    // load pass that is abandoned part-way by a register write.
    task automatic test_register_edges();
        // Zero counts behave as a single cell.
        set_shape(9'd0, 9'd0);
        send_load(16'h8000);
        send_query(8'd0, 8'd0, 8'd0, 8'd0);
        send_query(8'd0, 8'd0, 8'd0, 8'd1);
        send_query(8'd0, 8'd0, 8'd1, 8'd0);
        send_load(16'h7FFF);
        wait_results_drained();
        // Spare indexes must neither change the shape nor restart loading.
        write_register(REG_SPARE_2, 9'h1FF);
        write_register(REG_SPARE_3, 9'h000);
        send_query(8'd0, 8'd0, 8'd0, 8'd0);

        // A tall single column, clipped from the all-ones count.
        set_shape(9'h1FF, 9'd0);
        load_elements(100);
        query_inside();
        wait_results_drained();
        write_register(REG_COL_COUNT, 9'd0);
        load_elements(256);
        send_query(8'd0, 8'd0, 8'd255, 8'd0);
        send_query(8'd255, 8'd0, 8'd255, 8'd0);
        send_query(8'd0, 8'd0, 8'd255, 8'd1);
        repeat (20) query_inside();

        // A wide single row, with a column count past the table size.
        set_shape(9'd0, 9'd300);
        load_elements(256);
        send_query(8'd0, 8'd0, 8'd0, 8'd255);
        send_query(8'd0, 8'd128, 8'd0, 8'd255);
        send_query(8'd0, 8'd0, 8'd1, 8'd255);
        repeat (20) query_inside();
        wait_results_drained();
    endtask

    // The receiver refuses results for a long stretch while the sender
    // keeps offering queries back to back, so the block fills and stalls.
    task automatic test_result_backpressure();
        set_shape(9'd4, 9'd4);
        sender_bursty = 1'b0;
        load_elements(16);
        wait_results_drained();
        hold_off_req = 1'b1;
        repeat (12) query_inside();
        wait_results_drained();
        sender_bursty = 1'b1;
    endtask

    // Many small matrices of random shape. Most of the traffic is complete
    // load passes followed by queries, with some queries during loading,
    // noise rectangles, surplus loads and abandoned passes mixed in.
    task automatic test_random_tables();
        int start;
        int rows;
        int cols;
        int kind;
        start = requests_sent;
        while (requests_sent - start < RANDOM_REQUESTS) begin
            case ($urandom_range(0, 7))
                0: begin
                    rows = $urandom_range(1, 4);
                    cols = $urandom_range(16, 48);
                end
                1: begin
                    rows = $urandom_range(16, 48);
                    cols = $urandom_range(1, 4);
                end
                default: begin
                    rows = $urandom_range(1, 10);
                    cols = $urandom_range(1, 10);
                end
            endcase
            wait_results_drained();
            if ($urandom_range(0, 1)) begin
                write_register(REG_ROW_COUNT, CFG_W'(rows));
                write_register(REG_COL_COUNT, CFG_W'(cols));
            end else begin
                write_register(REG_COL_COUNT, CFG_W'(cols));
                write_register(REG_ROW_COUNT, CFG_W'(rows));
            end
            sender_bursty = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 5) == 0) begin
                load_elements($urandom_range(0, rows * cols - 1));
                query_noise();
                wait_results_drained();
                write_register(REG_ROW_COUNT, CFG_W'(rows));
            end
            for (int i = 0; i < rows * cols; i++) begin
                if ($urandom_range(0, 9) == 0) query_inside();
                send_load(rand_element());
            end
            repeat ($urandom_range(4, 30)) begin
                kind = $urandom_range(0, 9);
                if (kind < 8) query_inside();
                else if (kind == 8) query_noise();
                else send_load(rand_element());
            end
        end
        sender_bursty = 1'b1;
        wait_results_drained();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_shape();
        test_small_matrix();
        test_register_edges();
        test_result_backpressure();
        test_random_tables();
        wait_results_drained();
        repeat (20) @(posedge i_clk);
        if (rect_results_due.size() != 0)
            report_mismatch($sformatf("%0d answers never came", rect_results_due.size()));
        if (mismatch_count == 0) begin
            $display("summed_area_rect_sum test passed");
        end else begin
            $display("summed_area_rect_sum test failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #4000000;
        $display("summed_area_rect_sum test failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/sat_pkg.sv
design/sat_mem.sv
design/sat_ctrl.sv
design/summed_area_rect_sum.sv
test/summed_area_rect_sum_tb.sv
